FILE: rtl/m1ump_pkg.sv
package m1ump_pkg;

    // UMP message type nibbles
    localparam logic [3:0] MT_SYSTEM   = 4'h1;
    localparam logic [3:0] MT_MIDI1_CV = 4'h2;
    localparam logic [3:0] MT_DATA_64  = 4'h3;

    // SysEx7 packet status nibbles
    localparam logic [3:0] SX_COMPLETE = 4'h0;
    localparam logic [3:0] SX_START    = 4'h1;
    localparam logic [3:0] SX_CONTINUE = 4'h2;
    localparam logic [3:0] SX_END      = 4'h3;

    // Number of payload bytes in one SysEx7 packet
    localparam int          SX_MAX   = 6;
    localparam logic [2:0]  SX_FULL  = 3'(SX_MAX);

    // MIDI 1.0 status bytes and status nibbles
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_NONE        = 8'h00;

    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
    localparam logic [3:0] NIB_CONTROL    = 4'hB;
    localparam logic [3:0] NIB_PROGRAM    = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
    localparam logic [3:0] NIB_PITCH_BEND = 4'hE;
    localparam logic [3:0] NIB_SYSTEM     = 4'hF;

    // Data byte count codes for a status byte
    localparam logic [1:0] NEED_0    = 2'd0;
    localparam logic [1:0] NEED_1    = 2'd1;
    localparam logic [1:0] NEED_2    = 2'd2;
    localparam logic [1:0] NEED_NONE = 2'd3;

    // Packet queue between the parser and the output stage
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [31:0] word_first;
        logic [31:0] word_second;
        logic        two_words;
    } pkt_t;

    // One queue entry holds every packet caused by one input byte. A second
    // packet only occurs after a SysEx flush, and then it is a 32-bit word.
    typedef struct packed {
        logic        has_second;
        pkt_t        pkt0;
        logic [31:0] word1;
    } entry_t;

    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] n;
        begin
            n = NEED_NONE;
            case (st[7:4])
                NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CONTROL,
                NIB_PITCH_BEND: n = NEED_2;
                NIB_PROGRAM, NIB_CHAN_PRESS: n = NEED_1;
                NIB_SYSTEM:
                begin
                    case (st)
                        ST_MTC_QFRAME, ST_SONG_SEL: n = NEED_1;
                        ST_SONG_POS: n = NEED_2;
                        ST_TUNE_REQ: n = NEED_0;
                        default: n = NEED_NONE;
                    endcase
                end
                default: n = NEED_NONE;
            endcase
            return n;
        end
    endfunction

endpackage

FILE: rtl/m1ump_front.sv
module m1ump_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          group,
    input  logic                in_fire,
    input  logic [7:0]          stream_byte,
    output logic                q_push,
    output m1ump_pkg::entry_t   q_entry
);

    localparam int SX_MAX_IDX = m1ump_pkg::SX_MAX - 1;

    logic [3:0] group_reg;
    logic [7:0] rs_reg, rs_next;
    logic       fdv_reg, fdv_next;
    logic [6:0] fd_reg, fd_next;
    logic       act_reg, act_next;
    logic [2:0] fill_reg, fill_next;
    logic       started_reg, started_next;
    logic [6:0] pay_reg [SX_MAX_IDX:0];

    logic       is_rt, is_status, sx_data, flush, eox, sx_full;
    logic [2:0] fill_inc, n_bytes;
    logic [6:0] pay_m [SX_MAX_IDX:0];
    logic [7:0] b [SX_MAX_IDX:0];
    logic [3:0] sx_st;
    logic       sx_emit, word_emit;
    logic [3:0] w_mt;
    logic [7:0] w_st, w_d1, w_d2;
    logic [1:0] need_b, need_r;
    logic       rs_sys;
    logic [31:0] sx_wf, sx_ws, w_wf;

    assign is_rt     = (stream_byte[7:3] == 5'b11111);
    assign is_status = stream_byte[7];
    assign sx_data   = act_reg && !is_status;
    assign eox       = act_reg && (stream_byte == m1ump_pkg::ST_SYSEX_END);
    assign flush     = act_reg && is_status && !is_rt
                       && (stream_byte != m1ump_pkg::ST_SYSEX_START)
                       && (stream_byte != m1ump_pkg::ST_SYSEX_END);
    assign fill_inc  = fill_reg + 3'd1;
    assign sx_full   = sx_data && (fill_inc == m1ump_pkg::SX_FULL);
    assign n_bytes   = sx_full ? m1ump_pkg::SX_FULL : fill_reg;
    assign need_b    = m1ump_pkg::data_count(stream_byte);
    assign need_r    = m1ump_pkg::data_count(rs_reg);
    assign rs_sys    = (rs_reg[7:4] == m1ump_pkg::NIB_SYSTEM);

    // Payload view that already holds the byte arriving this cycle.
    always_comb
    begin
        for (int i = 0; i < m1ump_pkg::SX_MAX; i++)
        begin
            pay_m[i] = (sx_data && (fill_reg == 3'(i))) ? stream_byte[6:0] : pay_reg[i];
            b[i]     = (3'(i) < n_bytes) ? {1'b0, pay_m[i]} : 8'h00;
        end
    end

    always_comb
    begin
        if (sx_full)
            sx_st = started_reg ? m1ump_pkg::SX_CONTINUE : m1ump_pkg::SX_START;
        else
            sx_st = started_reg ? m1ump_pkg::SX_END : m1ump_pkg::SX_COMPLETE;
    end

    assign sx_emit = flush || eox || sx_full;
    assign sx_wf = {m1ump_pkg::MT_DATA_64, group_reg, sx_st, 1'b0, n_bytes, b[0], b[1]};
    assign sx_ws = {b[2], b[3], b[4], b[5]};

    always_comb
    begin
        rs_next      = rs_reg;
        fdv_next     = fdv_reg;
        fd_next      = fd_reg;
        act_next     = act_reg;
        fill_next    = fill_reg;
        started_next = started_reg;
        word_emit    = 1'b0;
        w_mt         = m1ump_pkg::MT_SYSTEM;
        w_st         = stream_byte;
        w_d1         = 8'h00;
        w_d2         = 8'h00;
        if (is_rt)
        begin
            word_emit = 1'b1;
        end
        else if (stream_byte == m1ump_pkg::ST_SYSEX_START)
        begin
            rs_next      = m1ump_pkg::ST_NONE;
            fdv_next     = 1'b0;
            act_next     = 1'b1;
            fill_next    = 3'd0;
            started_next = 1'b0;
        end
        else if (stream_byte == m1ump_pkg::ST_SYSEX_END)
        begin
            if (act_reg)
            begin
                act_next     = 1'b0;
                fill_next    = 3'd0;
                started_next = 1'b0;
            end
            rs_next = m1ump_pkg::ST_NONE;
        end
        else if (sx_data)
        begin
            if (sx_full)
            begin
                fill_next    = 3'd0;
                started_next = 1'b1;
            end
            else
            begin
                fill_next = fill_inc;
            end
        end
        else
        begin
            if (act_reg)
            begin
                act_next     = 1'b0;
                fill_next    = 3'd0;
                started_next = 1'b0;
            end
            if (is_status)
            begin
                rs_next  = (need_b == m1ump_pkg::NEED_NONE) ? m1ump_pkg::ST_NONE : stream_byte;
                fdv_next = 1'b0;
                if (need_b == m1ump_pkg::NEED_0)
                begin
                    word_emit = 1'b1;
                    rs_next   = m1ump_pkg::ST_NONE;
                end
            end
            else if (rs_reg != m1ump_pkg::ST_NONE)
            begin
                w_mt = rs_sys ? m1ump_pkg::MT_SYSTEM : m1ump_pkg::MT_MIDI1_CV;
                w_st = rs_reg;
                case (need_r)
                    m1ump_pkg::NEED_1:
                    begin
                        word_emit = 1'b1;
                        w_d1      = {1'b0, stream_byte[6:0]};
                        if (rs_sys)
                            rs_next = m1ump_pkg::ST_NONE;
                    end
                    m1ump_pkg::NEED_2:
                    begin
                        if (!fdv_reg)
                        begin
                            fd_next  = stream_byte[6:0];
                            fdv_next = 1'b1;
                        end
                        else
                        begin
                            word_emit = 1'b1;
                            w_d1      = {1'b0, fd_reg};
                            w_d2      = {1'b0, stream_byte[6:0]};
                            fdv_next  = 1'b0;
                            if (rs_sys)
                                rs_next = m1ump_pkg::ST_NONE;
                        end
                    end
                    default: rs_next = m1ump_pkg::ST_NONE;
                endcase
            end
        end
    end

    assign w_wf = {w_mt, group_reg, w_st, w_d1, w_d2};

    always_comb
    begin
        q_push                       = in_fire && (sx_emit || word_emit);
        q_entry.has_second           = sx_emit && word_emit;
        q_entry.pkt0.word_first      = sx_emit ? sx_wf : w_wf;
        q_entry.pkt0.word_second     = sx_emit ? sx_ws : 32'h0;
        q_entry.pkt0.two_words       = sx_emit;
        q_entry.word1                = w_wf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg   <= 4'h0;
            rs_reg      <= m1ump_pkg::ST_NONE;
            fdv_reg     <= 1'b0;
            fd_reg      <= 7'h00;
            act_reg     <= 1'b0;
            fill_reg    <= 3'd0;
            started_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                group_reg <= group;
            if (in_fire)
            begin
                rs_reg      <= rs_next;
                fdv_reg     <= fdv_next;
                fd_reg      <= fd_next;
                act_reg     <= act_next;
                fill_reg    <= fill_next;
                started_reg <= started_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && sx_data)
            pay_reg[fill_reg] <= stream_byte[6:0];
    end

endmodule

FILE: rtl/m1ump_queue.sv
module m1ump_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  m1ump_pkg::entry_t   wr_data,
    input  logic                rd_en,
    output m1ump_pkg::entry_t   head,
    output logic                q_empty,
    output logic                q_full
);

    m1ump_pkg::entry_t             mem_reg [m1ump_pkg::QDEPTH-1:0];
    logic [m1ump_pkg::QAW-1:0]     wp_reg, rp_reg;
    logic [m1ump_pkg::QCW-1:0]     cnt_reg, cnt_next;
    logic                          do_wr, do_rd;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == m1ump_pkg::QCW'(m1ump_pkg::QDEPTH));
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign head    = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
                wp_reg <= wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

FILE: rtl/m1ump_back.sv
module m1ump_back (
    input  logic                clk,
    input  logic                rst_n,
    input  m1ump_pkg::entry_t   head,
    input  logic                q_empty,
    input  logic                pop,
    output logic                q_pop,
    output logic                empty,
    output logic [31:0]         word_first,
    output logic [31:0]         word_second,
    output logic                two_words,
    output logic                last
);

    // Set while the second packet of the head entry is on the ports.
    logic sub_reg;
    logic fire;

    assign empty       = q_empty;
    assign fire        = pop && !q_empty;
    assign last        = sub_reg || !head.has_second;
    assign q_pop       = fire && last;
    assign word_first  = sub_reg ? head.word1 : head.pkt0.word_first;
    assign word_second = sub_reg ? 32'h0 : head.pkt0.word_second;
    assign two_words   = sub_reg ? 1'b0 : head.pkt0.two_words;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 1'b0;
        else if (fire)
            sub_reg <= !last;
    end

endmodule

FILE: rtl/midi1_bytes_to_ump_packets_top.sv
// MIDI 1.0 byte stream to Universal MIDI Packet translator. Push one raw MIDI
// byte per transaction on stream_byte; pop UMP packets from the result side.
// Channel-voice messages come out as 32-bit MIDI 1.0 words (type 2), system
// common and real-time messages as 32-bit system words (type 1), and SysEx
// as 64-bit SysEx7 packets (type 3, two_words high) of up to six payload
// bytes. Running status is honored, real-time bytes pass through anywhere,
// stray data bytes and the undefined statuses F4/F5 are dropped. A status
// byte that aborts a SysEx yields the flushed end packet and then, for Tune
// Request, its own word; last marks the final packet caused by one byte.
// Every packet carries the group written through cfg_we/group, which should
// only be changed while the block is idle. Rate: one input byte is accepted
// every clock cycle unless full; a byte's packets reach the result ports
// from the head of a four-entry packet queue between the parser and the
// output stage; push is refused only when that queue is full. A byte that
// causes two packets occupies one queue entry but takes two pop transactions.

module midi1_bytes_to_ump_packets_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  group,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  stream_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] word_first,
    output logic [31:0] word_second,
    output logic        two_words,
    output logic        last
);

    logic              in_fire;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    m1ump_pkg::entry_t q_entry;
    m1ump_pkg::entry_t q_head;

    // A transaction on the input side is taken whenever the queue has room.
    assign in_fire = push && !full;

    // Parser: running status, pending data byte and the SysEx7 assembler.
    m1ump_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .group       (group),
        .in_fire     (in_fire),
        .stream_byte (stream_byte),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    // Packet queue decouples the parser from the consumer.
    m1ump_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_entry),
        .rd_en   (q_pop),
        .head    (q_head),
        .q_empty (q_empty),
        .q_full  (full)
    );

    // Output stage: presents one packet at a time from the head entry.
    m1ump_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .pop         (pop),
        .q_pop       (q_pop),
        .empty       (empty),
        .word_first  (word_first),
        .word_second (word_second),
        .two_words   (two_words),
        .last        (last)
    );

    // Only a SysEx flush is ever followed by another packet from the same byte.
    a_not_last_is_sysex: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> two_words)
        else $error("non-final packet is not a SysEx7 packet");

    // 64-bit packets are data type, 32-bit packets carry a zero second word.
    a_packet_shape: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (two_words ? (word_first[31:28] == m1ump_pkg::MT_DATA_64)
                              : (word_second == 32'h0)))
        else $error("packet type and width disagree");

    // A full queue always has a packet to show.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while result side empty");

    // A packet that is not popped stays on the result ports unchanged.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(word_first) && $stable(word_second)
                              && $stable(two_words) && $stable(last)))
        else $error("waiting result changed before it was popped");

endmodule
